FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands, reset-qualified on the synchronous rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the same edge
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ipa_pkg.sv
// ----------------------------------------------------------------------------
// ipa_pkg
// Shared widths, codes and defaults for the address pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ipa_pkg;

  localparam int unsigned HOST_BITS_DEF = 8;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned COUNT_W       = 8;

  // leaf marks; internal nodes hold 1 when full, so any non-zero word is full
  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_OCCUPIED = 2'd1,
    ST_RESERVED = 2'd2
  } leaf_st_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK    = 2'd0,
    RES_OTHER = 2'd1,
    RES_FAIL  = 2'd2
  } res_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } act_t;

endpackage

`default_nettype wire

FILE: rtl/ipa_in_if.sv
// ----------------------------------------------------------------------------
// ipa_in_if
// Request channel: action, optional preferred host, address to release.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipa_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic                       has_request;
  logic [ipa_pkg::ADDR_W-1:0] request_address;

  modport source (output valid, action, has_request, request_address, input ready);
  modport sink   (input valid, action, has_request, request_address, output ready);
endinterface

`default_nettype wire

FILE: rtl/ipa_out_if.sv
// ----------------------------------------------------------------------------
// ipa_out_if
// Result channel: granted address, status and free host count.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipa_out_if;
  logic                         valid;
  logic                         ready;
  logic [ipa_pkg::ADDR_W-1:0]   granted_address;
  logic [ipa_pkg::STATUS_W-1:0] status;
  logic [ipa_pkg::COUNT_W-1:0]  free_count;

  modport source (output valid, granted_address, status, free_count, input ready);
  modport sink   (input valid, granted_address, status, free_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/ip_address_pool_allocator_top.sv
// Flow: a release, or a grant at the start host, reads and writes the leaf and
//   refreshes the full marks up to the root; other grants climb and descend
//   first; a refused release stops at the leaf, a failed allocate at the root.
// Throughput: one word in flight; in_ch.ready rises with out_ch.valid.
// Reset: synchronous rst_n; then a clearing pass writes every node RAM word
//   while in_ch.ready stays low.
// ----------------------------------------------------------------------------
// ip_address_pool_allocator_top
// Subnet address pool kept as a heap of full marks over the host leaves,
// walked by a small sequencer through one shared node RAM.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ip_address_pool_allocator_top #(
  parameter int unsigned HOST_BITS = ipa_pkg::HOST_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  ipa_in_if.sink                           in_ch,
  ipa_out_if.source                        out_ch,
  input  wire logic                        cfg_wr_en,
  input  wire logic [ipa_pkg::ADDR_W-1:0]  cfg_wr_data
);

  localparam int unsigned NODE_W = HOST_BITS + 1;
  localparam int unsigned DEPTH  = 2 ** NODE_W;
  localparam int unsigned EXT_W  = HOST_BITS + ipa_pkg::COUNT_W;
  localparam logic [HOST_BITS-1:0] FREE_INIT = HOST_BITS'(DEPTH / 2 - 3);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LEAF_RD, S_LEAF_CHK, S_UP, S_UP_CHK,
    S_DOWN, S_DOWN_CHK, S_UPD_LEAF, S_REF, S_REF_CHK, S_FIN
  } state_t;

  state_t                       state_r;
  logic [NODE_W-1:0]            clr_cnt_r;
  logic [NODE_W-1:0]            node_r;
  logic [HOST_BITS-1:0]         start_r;
  logic [HOST_BITS-1:0]         host_r;
  logic                         act_r;
  logic                         has_req_r;
  logic                         fail_r;
  logic                         cur_full_r;
  logic [HOST_BITS-1:0]         free_r;
  logic [ipa_pkg::ADDR_W-1:0]   net_r;
  logic                         out_valid_r;
  logic [ipa_pkg::ADDR_W-1:0]   out_granted_r;
  logic [ipa_pkg::STATUS_W-1:0] out_status_r;
  logic [ipa_pkg::COUNT_W-1:0]  out_count_r;

  logic                         ram_we;
  logic [NODE_W-1:0]            ram_waddr;
  logic [1:0]                   ram_wdata;
  logic [NODE_W-1:0]            ram_raddr;
  logic [1:0]                   ram_rdata;
  logic                         rd_full;
  logic                         parent_full;
  logic [1:0]                   clr_val;
  logic                         fin_load;
  logic [HOST_BITS-1:0]         free_nxt;
  logic [EXT_W-1:0]             free_ext;

  ipa_ram #(
    .WIDTH (2),
    .DEPTH (DEPTH)
  ) u_node_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  assign rd_full     = (ram_rdata != 2'd0);
  assign parent_full = cur_full_r && rd_full;

  // reset image: hosts 0, all-ones and all-ones minus one reserved,
  // the last internal node (parent of the top two hosts) full
  always_comb begin
    clr_val = 2'd0;
    if (clr_cnt_r[NODE_W-1] && ((clr_cnt_r[HOST_BITS-1:0] == '0) ||
        (clr_cnt_r[HOST_BITS-1:1] == '1))) begin
      clr_val = ipa_pkg::ST_RESERVED;
    end else if (clr_cnt_r == {1'b0, {HOST_BITS{1'b1}}}) begin
      clr_val = 2'd1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node_r;
    ram_wdata = 2'd0;
    ram_raddr = node_r;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = clr_val;
      end
      S_UP:       ram_raddr = node_r | NODE_W'(1);
      S_DOWN:     ram_raddr = {node_r[NODE_W-2:0], 1'b0};
      S_REF:      ram_raddr = node_r ^ NODE_W'(1);
      S_UPD_LEAF: begin
        ram_we    = 1'b1;
        ram_wdata = (act_r == ipa_pkg::ACT_FREE) ? ipa_pkg::ST_FREE : ipa_pkg::ST_OCCUPIED;
      end
      S_REF_CHK: begin
        ram_we    = 1'b1;
        ram_waddr = {1'b0, node_r[NODE_W-1:1]};
        ram_wdata = {1'b0, parent_full};
      end
      default: ram_raddr = node_r;
    endcase
  end

  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    free_nxt = free_r;
    if (!fail_r) begin
      free_nxt = (act_r == ipa_pkg::ACT_FREE) ? free_r + HOST_BITS'(1)
                                             : free_r - HOST_BITS'(1);
    end
  end

  assign free_ext = {{ipa_pkg::COUNT_W{1'b0}}, free_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      free_r      <= FREE_INIT;
      net_r       <= '0;
      out_valid_r <= 1'b0;
      fail_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        net_r <= cfg_wr_data;
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + NODE_W'(1);
          if (clr_cnt_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            act_r     <= in_ch.action;
            has_req_r <= in_ch.has_request;
            fail_r    <= 1'b0;
            start_r   <= (in_ch.action == ipa_pkg::ACT_FREE || in_ch.has_request)
                         ? in_ch.request_address[HOST_BITS-1:0] : '0;
            node_r    <= {1'b1, ((in_ch.action == ipa_pkg::ACT_FREE ||
                          in_ch.has_request) ? in_ch.request_address[HOST_BITS-1:0]
                                             : {HOST_BITS{1'b0}})};
            state_r   <= S_LEAF_RD;
          end
        end
        S_LEAF_RD: state_r <= S_LEAF_CHK;
        S_LEAF_CHK: begin
          if (act_r == ipa_pkg::ACT_FREE) begin
            if (ram_rdata == ipa_pkg::ST_OCCUPIED) begin
              state_r <= S_UPD_LEAF;
            end else begin
              fail_r  <= 1'b1;
              state_r <= S_FIN;
            end
          end else begin
            state_r <= rd_full ? S_UP : S_UPD_LEAF;
          end
        end
        S_UP: begin
          if (node_r == NODE_W'(1)) begin
            fail_r  <= 1'b1;
            state_r <= S_FIN;
          end else if (!node_r[0]) begin
            node_r  <= node_r | NODE_W'(1);
            state_r <= S_UP_CHK;
          end else begin
            node_r <= {1'b0, node_r[NODE_W-1:1]};
          end
        end
        S_UP_CHK: begin
          if (rd_full) begin
            node_r  <= {1'b0, node_r[NODE_W-1:1]};
            state_r <= S_UP;
          end else begin
            state_r <= S_DOWN;
          end
        end
        S_DOWN: begin
          state_r <= node_r[NODE_W-1] ? S_UPD_LEAF : S_DOWN_CHK;
        end
        S_DOWN_CHK: begin
          node_r  <= {node_r[NODE_W-2:0], rd_full};
          state_r <= S_DOWN;
        end
        S_UPD_LEAF: begin
          host_r     <= node_r[HOST_BITS-1:0];
          cur_full_r <= (act_r == ipa_pkg::ACT_ALLOC);
          state_r    <= S_REF;
        end
        S_REF: begin
          state_r <= (node_r == NODE_W'(1)) ? S_FIN : S_REF_CHK;
        end
        S_REF_CHK: begin
          cur_full_r <= parent_full;
          node_r     <= {1'b0, node_r[NODE_W-1:1]};
          state_r    <= S_REF;
        end
        S_FIN: begin
          if (fin_load) begin
            free_r  <= free_nxt;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_count_r <= (free_ext > EXT_W'(255)) ? 8'hff : free_ext[ipa_pkg::COUNT_W-1:0];
      if (fail_r) begin
        out_granted_r <= '0;
        out_status_r  <= ipa_pkg::RES_FAIL;
      end else if (act_r == ipa_pkg::ACT_FREE) begin
        out_granted_r <= '0;
        out_status_r  <= ipa_pkg::RES_OK;
      end else begin
        out_granted_r <= {net_r[ipa_pkg::ADDR_W-1:HOST_BITS], host_r};
        out_status_r  <= (!has_req_r || host_r == start_r) ? ipa_pkg::RES_OK
                                                           : ipa_pkg::RES_OTHER;
      end
    end
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.granted_address = out_granted_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.free_count      = out_count_r;

  `ASSERT_IMPL(a_fail_zero,
    $rose(out_valid_r) && out_status_r == ipa_pkg::RES_FAIL,
    out_granted_r == '0, "failed word carries an address")
  `ASSERT_NEXT(a_alloc_dec,
    fin_load && !fail_r && act_r == ipa_pkg::ACT_ALLOC,
    free_r == $past(free_r) - HOST_BITS'(1), "free count not decremented on grant")
  `ASSERT_IMPL(a_node_live,
    state_r != S_IDLE && state_r != S_CLEAR && state_r != S_FIN,
    node_r != '0, "walk reached node zero")

endmodule

`default_nettype wire

FILE: rtl/ipa_ram.sv
// ----------------------------------------------------------------------------
// ipa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ipa_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sim/tb_ip_address_pool_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ip_address_pool_allocator_top
// Self-checking bench for the subnet address pool. A queue-fed driver offers
// allocate and release words, a shadow pool predicts every response, and a
// monitor checks each response word in order. A short directed pass covers
// reserved hosts, the top of the range and release corner cases. Random
// phases fill, drain and mix the pool, each under its own network prefix;
// all but the last add random back-pressure and idle bursts on both sides.
// ----------------------------------------------------------------------------

module tb_ip_address_pool_allocator_top;

  localparam int unsigned HB        = ipa_pkg::HOST_BITS_DEF;
  localparam int unsigned AW        = ipa_pkg::ADDR_W;
  localparam int unsigned CW        = ipa_pkg::COUNT_W;
  localparam int unsigned HOSTS     = 1 << HB;
  localparam int unsigned HOST_MASK = HOSTS - 1;
  localparam int unsigned SETTLE    = 6 * HB + 12;
  localparam int unsigned LIMIT     = 400000;
  localparam int unsigned HOLD_LEN  = 400;
  localparam int unsigned MAX_SHOWN = 10;

  typedef struct packed {
    ipa_pkg::act_t action;
    logic          has_request;
    logic [AW-1:0] addr;
  } pool_req_t;

  typedef struct packed {
    logic [AW-1:0] granted;
    ipa_pkg::res_t status;
    logic [CW-1:0] free_count;
  } pool_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [AW-1:0] cfg_wr_data = '0;

  ipa_in_if  in_ch ();
  ipa_out_if out_ch ();

  ip_address_pool_allocator_top #(.HOST_BITS(HB)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // shadow pool
  ipa_pkg::leaf_st_t host_mark [HOSTS];
  logic [AW-1:0]     pool_prefix;
  int unsigned       free_hosts;

  pool_req_t   pending_reqs [$];
  pool_rsp_t   expected_rsps [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned hold_cnt = 0;
  bit          hold_go = 1'b0;
  bit          hold_taken = 1'b0;
  bit          calm = 1'b0;

  function automatic void reset_pool();
    for (int h = 0; h < HOSTS; h++) host_mark[h] = ipa_pkg::ST_FREE;
    host_mark[0]           = ipa_pkg::ST_RESERVED;
    host_mark[HOST_MASK]   = ipa_pkg::ST_RESERVED;
    host_mark[HOST_MASK-1] = ipa_pkg::ST_RESERVED;
    free_hosts  = HOSTS - 3;
    pool_prefix = '0;
  endfunction

  function automatic pool_rsp_t predict_pool_step(pool_req_t rq);
    pool_rsp_t   rsp;
    int unsigned start;
    int unsigned host;
    bit          found;
    rsp.granted = '0;
    rsp.status  = ipa_pkg::RES_FAIL;
    found = 1'b0;
    if (rq.action == ipa_pkg::ACT_ALLOC) begin
      start = rq.has_request ? (rq.addr & HOST_MASK) : 0;
      for (int unsigned h = start; h < HOSTS && !found; h++) begin
        if (host_mark[h] == ipa_pkg::ST_FREE) begin
          host = h;
          found = 1'b1;
        end
      end
      if (found) begin
        host_mark[host] = ipa_pkg::ST_OCCUPIED;
        free_hosts--;
        rsp.granted = (pool_prefix & ~AW'(HOST_MASK)) | AW'(host);
        rsp.status  = (!rq.has_request || host == start) ? ipa_pkg::RES_OK
                                                         : ipa_pkg::RES_OTHER;
      end
    end else begin
      host = rq.addr & HOST_MASK;
      if (host_mark[host] == ipa_pkg::ST_OCCUPIED) begin
        host_mark[host] = ipa_pkg::ST_FREE;
        free_hosts++;
        rsp.status = ipa_pkg::RES_OK;
      end
    end
    rsp.free_count = (free_hosts > 255) ? 8'hff : CW'(free_hosts);
    return rsp;
  endfunction

  // release targets are picked from the shadow pool so most hit an occupied host
  function automatic pool_req_t random_word(int unsigned alloc_pct);
    pool_req_t   rq;
    int unsigned base;
    int unsigned host;
    bit          hit;
    rq.addr        = $urandom;
    rq.has_request = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 10) begin
      rq.action = ipa_pkg::act_t'($urandom_range(0, 1));
    end else if ($urandom_range(0, 99) < alloc_pct) begin
      rq.action = ipa_pkg::ACT_ALLOC;
    end else begin
      rq.action = ipa_pkg::ACT_FREE;
      base = $urandom_range(0, HOST_MASK);
      hit  = 1'b0;
      for (int unsigned k = 0; k < HOSTS && !hit; k++) begin
        host = (base + k) & HOST_MASK;
        if (host_mark[host] == ipa_pkg::ST_OCCUPIED) hit = 1'b1;
      end
      if (hit) rq.addr[HB-1:0] = host[HB-1:0];
    end
    return rq;
  endfunction

  function automatic pool_req_t mk_word(ipa_pkg::act_t act, logic req, logic [AW-1:0] addr);
    pool_req_t rq;
    rq.action      = act;
    rq.has_request = req;
    rq.addr        = addr;
    return rq;
  endfunction

  task automatic push_word(pool_req_t rq);
    @(negedge clk);
    while (pending_reqs.size() >= 4) @(negedge clk);
    pending_reqs.push_back(rq);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(negedge clk);
  endtask

  task automatic write_prefix(logic [AW-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    pool_prefix = value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(int unsigned count, int unsigned alloc_pct);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2 && alloc_pct < 50) wait_drained();
      if (i == 100) hold_go = 1'b1;
      push_word(random_word(alloc_pct));
    end
  endtask

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.action          = ipa_pkg::ACT_ALLOC;
    in_ch.has_request     = 1'b0;
    in_ch.request_address = '0;
    out_ch.ready          = 1'b0;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_rsps.push_back(predict_pool_step(pending_reqs.pop_front()));
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0) begin
          send_gap    <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap    <= $urandom_range(0, 5);
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_ch.valid           <= 1'b1;
          in_ch.action          <= pending_reqs[0].action;
          in_ch.has_request     <= pending_reqs[0].has_request;
          in_ch.request_address <= pending_reqs[0].addr;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go && !hold_taken) begin
      hold_cnt   <= HOLD_LEN;
      hold_taken <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    pool_rsp_t exp_rsp;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: unexpected word addr=%h status=%0d count=%0d", $realtime,
                     out_ch.granted_address, out_ch.status, out_ch.free_count);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (out_ch.granted_address !== exp_rsp.granted ||
              out_ch.status !== exp_rsp.status ||
              out_ch.free_count !== exp_rsp.free_count) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("%0t: exp addr=%h status=%0d count=%0d, got addr=%h status=%0d count=%0d",
                       $realtime, exp_rsp.granted, exp_rsp.status, exp_rsp.free_count,
                       out_ch.granted_address, out_ch.status, out_ch.free_count);
          end
        end
      end
      if (hold_cnt != 0) begin
        out_ch.ready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall   <= recv_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_stall   <= $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    reset_pool();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed pass, reset prefix
    push_word(mk_word(ipa_pkg::ACT_ALLOC, 1'b0, 32'h0000_0000));
    push_word(mk_word(ipa_pkg::ACT_ALLOC, 1'b1, 32'h0000_0000));
    push_word(mk_word(ipa_pkg::ACT_ALLOC, 1'b1, 32'h0000_0001));
    push_word(mk_word(ipa_pkg::ACT_ALLOC, 1'b1, 32'hffff_ffff));
    push_word(mk_word(ipa_pkg::ACT_ALLOC, 1'b1, 32'h0000_00fe));
    push_word(mk_word(ipa_pkg::ACT_ALLOC, 1'b1, 32'h0000_00fd));
    push_word(mk_word(ipa_pkg::ACT_ALLOC, 1'b1, 32'h0000_00fd));
    push_word(mk_word(ipa_pkg::ACT_ALLOC, 1'b1, 32'h1234_5680));
    push_word(mk_word(ipa_pkg::ACT_FREE,  1'b0, 32'habcd_ef80));
    push_word(mk_word(ipa_pkg::ACT_FREE,  1'b0, 32'h0000_0080));
    push_word(mk_word(ipa_pkg::ACT_FREE,  1'b0, 32'h0000_0000));
    push_word(mk_word(ipa_pkg::ACT_FREE,  1'b0, 32'h0000_00ff));
    push_word(mk_word(ipa_pkg::ACT_FREE,  1'b0, 32'h0000_00fe));
    push_word(mk_word(ipa_pkg::ACT_FREE,  1'b1, 32'h0000_0001));
    push_word(mk_word(ipa_pkg::ACT_ALLOC, 1'b0, 32'hffff_ffff));
    push_word(mk_word(ipa_pkg::ACT_FREE,  1'b1, 32'hffff_ff01));
    push_word(mk_word(ipa_pkg::ACT_ALLOC, 1'b1, 32'h0000_0080));
    push_word(mk_word(ipa_pkg::ACT_ALLOC, 1'b1, 32'h0000_00fc));
    push_word(mk_word(ipa_pkg::ACT_ALLOC, 1'b1, 32'h0000_00fc));
    push_word(mk_word(ipa_pkg::ACT_FREE,  1'b0, 32'h0000_00fd));

    wait_drained();
    write_prefix(32'hffff_ffff);
    run_phase(300, 85);

    wait_drained();
    write_prefix($urandom);
    run_phase(300, 20);

    wait_drained();
    write_prefix(32'h0000_0000);
    run_phase(200, 55);

    wait_drained();
    write_prefix($urandom);
    calm = 1'b1;
    run_phase(150, 50);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
